// ===== rtl/kdbox_pkg.sv =====
// ----------------------------------------------------------------------------
// kdbox_pkg
// Shared widths, types and helpers for the kd box candidate prune test.
// ----------------------------------------------------------------------------
package kdbox_pkg;

  localparam int DIMENSIONS    = 2;
  localparam int COORD_WIDTH   = 16;
  localparam int WIDE_WIDTH    = 32;
  localparam int MUL_INT_BITS  = 12;
  localparam int MUL_FRAC_BITS = 6;
  localparam int MUL_WIDTH     = MUL_INT_BITS + MUL_FRAC_BITS;
  localparam int FIELD_WIDTH   = 32;
  localparam int PROD_WIDTH    = 2 * MUL_WIDTH;

  typedef logic [FIELD_WIDTH-1:0]       field_t;
  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [WIDE_WIDTH-1:0]  wide_t;
  typedef logic signed [MUL_WIDTH-1:0]   mul_t;
  typedef logic signed [PROD_WIDTH-1:0]  prod_t;

  localparam logic signed [63:0] MUL_MAX = 64'((65'd1 << (MUL_WIDTH - 1)) - 65'd1);
  localparam logic signed [63:0] MUL_MIN = -MUL_MAX - 64'sd1;

  // Coordinate d of a packed word; bits past the top of the word read as zero.
  function automatic coord_t coord_of(input field_t word, input int d);
    logic [2*FIELD_WIDTH-1:0] ext;
    ext = {{FIELD_WIDTH{1'b0}}, word} >> (d * COORD_WIDTH);
    return coord_t'(ext[COORD_WIDTH-1:0]);
  endfunction

  // Clamp a wide value into the multiplier operand range.
  function automatic mul_t sat_mul_in(input wide_t v);
    logic signed [63:0] v64;
    v64 = 64'(v);
    if (v64 > MUL_MAX) begin
      return mul_t'(MUL_MAX);
    end else if (v64 < MUL_MIN) begin
      return mul_t'(MUL_MIN);
    end
    return mul_t'(v64);
  endfunction

endpackage

// ===== rtl/kdbox_dim.sv =====
// ----------------------------------------------------------------------------
// kdbox_dim
// One dimension: difference, corner pick, and the two scaled products.
// ----------------------------------------------------------------------------
module kdbox_dim (
  input  kdbox_pkg::coord_t closest,
  input  kdbox_pkg::coord_t cand,
  input  kdbox_pkg::coord_t low,
  input  kdbox_pkg::coord_t high,
  output kdbox_pkg::wide_t  sq,
  output kdbox_pkg::wide_t  box
);

  kdbox_pkg::wide_t c;
  kdbox_pkg::wide_t e;
  kdbox_pkg::mul_t  c_sat;
  kdbox_pkg::mul_t  e_sat;
  kdbox_pkg::prod_t sq_prod;
  kdbox_pkg::prod_t box_prod;

  always_comb begin
    c = kdbox_pkg::WIDE_WIDTH'(cand) - kdbox_pkg::WIDE_WIDTH'(closest);
    // corner that lies furthest towards the candidate
    if (c > 0) begin
      e = kdbox_pkg::WIDE_WIDTH'(high) - kdbox_pkg::WIDE_WIDTH'(closest);
    end else begin
      e = kdbox_pkg::WIDE_WIDTH'(low) - kdbox_pkg::WIDE_WIDTH'(closest);
    end
    c_sat    = kdbox_pkg::sat_mul_in(c);
    e_sat    = kdbox_pkg::sat_mul_in(e);
    sq_prod  = kdbox_pkg::PROD_WIDTH'(c_sat) * kdbox_pkg::PROD_WIDTH'(c_sat);
    box_prod = kdbox_pkg::PROD_WIDTH'(e_sat) * kdbox_pkg::PROD_WIDTH'(c_sat);
  end

  // floor shift, then wrap to the wide width
  assign sq  = kdbox_pkg::WIDE_WIDTH'(sq_prod >>> kdbox_pkg::MUL_FRAC_BITS);
  assign box = kdbox_pkg::WIDE_WIDTH'(box_prod >>> kdbox_pkg::MUL_FRAC_BITS);

endmodule

// ===== rtl/kd_box_candidate_prune_test.sv =====
// ----------------------------------------------------------------------------
// kd_box_candidate_prune_test
// Decides whether a candidate centre is farther than the closest centre
// from every point of a bounding box.
// ----------------------------------------------------------------------------
// A beat is taken whenever start is high; busy is always low, so a new beat
// may follow every cycle. The answer appears on too_far with done high for a
// single cycle. The vectors are registered as the beat is taken, then the
// per-dimension products, then the compare of the sums. There is no
// back-pressure on the result side.
module kd_box_candidate_prune_test (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  kdbox_pkg::field_t closest_centre,
  input  kdbox_pkg::field_t candidate_centre,
  input  kdbox_pkg::field_t box_low,
  input  kdbox_pkg::field_t box_high,
  output logic              done,
  output logic              too_far
);

  localparam int D = kdbox_pkg::DIMENSIONS;

  logic              v0;
  logic              v1;
  kdbox_pkg::field_t zs_r;
  kdbox_pkg::field_t z_r;
  kdbox_pkg::field_t lo_r;
  kdbox_pkg::field_t hi_r;

  kdbox_pkg::wide_t  sq_c  [D];
  kdbox_pkg::wide_t  box_c [D];
  kdbox_pkg::wide_t  sq_r  [D];
  kdbox_pkg::wide_t  box_r [D];

  kdbox_pkg::wide_t  sq_sum;
  kdbox_pkg::wide_t  box_sum;
  kdbox_pkg::wide_t  box2;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0   <= 1'b0;
      v1   <= 1'b0;
      done <= 1'b0;
    end else begin
      v0   <= start && !busy;
      v1   <= v0;
      done <= v1;
    end
  end

  always_ff @(posedge clk) begin
    zs_r <= closest_centre;
    z_r  <= candidate_centre;
    lo_r <= box_low;
    hi_r <= box_high;
  end

  for (genvar d = 0; d < D; d++) begin : g_dim
    kdbox_dim u_dim (
      .closest (kdbox_pkg::coord_of(zs_r, d)),
      .cand    (kdbox_pkg::coord_of(z_r, d)),
      .low     (kdbox_pkg::coord_of(lo_r, d)),
      .high    (kdbox_pkg::coord_of(hi_r, d)),
      .sq      (sq_c[d]),
      .box     (box_c[d])
    );

    always_ff @(posedge clk) begin
      sq_r[d]  <= sq_c[d];
      box_r[d] <= box_c[d];
    end
  end

  always_comb begin
    sq_sum  = '0;
    box_sum = '0;
    for (int d = 0; d < D; d++) begin
      sq_sum  = sq_sum + sq_r[d];
      box_sum = box_sum + box_r[d];
    end
    box2 = box_sum <<< 1;
  end

  always_ff @(posedge clk) begin
    too_far <= (sq_sum > box2);
  end

  a_start_to_done : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ##2 done)
    else $error("accepted beat produced no result");

  a_done_has_source : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(v0, 2))
    else $error("result without an accepted beat");

  a_mid_to_done : assert property (@(posedge clk) disable iff (rst)
    v1 |=> done)
    else $error("product stage lost a beat");

endmodule
